// ----- design/bxg_pkg.sv -----
// bxg_pkg: shared types, step codes and control program for the binary extended gcd block
`timescale 1ns / 1ps

package bxg_pkg;

   // width of the step counter
   localparam int PC_BITS = 4;

   // step addresses in the control program
   localparam logic [PC_BITS-1:0] STEP_CHECK   = 4'd0;
   localparam logic [PC_BITS-1:0] STEP_STRIP   = 4'd1;
   localparam logic [PC_BITS-1:0] STEP_INIT    = 4'd2;
   localparam logic [PC_BITS-1:0] STEP_HALVE_U = 4'd3;
   localparam logic [PC_BITS-1:0] STEP_HALVE_V = 4'd4;
   localparam logic [PC_BITS-1:0] STEP_SUB     = 4'd5;
   localparam logic [PC_BITS-1:0] STEP_COPY    = 4'd6;
   localparam logic [PC_BITS-1:0] STEP_FIX     = 4'd7;
   localparam logic [PC_BITS-1:0] STEP_DONE    = 4'd8;
   localparam logic [PC_BITS-1:0] STEP_ERR     = 4'd9;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP     = 4'd0,
      OP_STRIP   = 4'd1,
      OP_INIT    = 4'd2,
      OP_HALVE_U = 4'd3,
      OP_HALVE_V = 4'd4,
      OP_SUB     = 4'd5,
      OP_COPY    = 4'd6,
      OP_ADD_X   = 4'd7,
      OP_FINISH  = 4'd8,
      OP_ERR     = 4'd9
   } op_type;

   // jump conditions tested by the sequencer
   typedef enum logic [2:0] {
      COND_ALWAYS     = 3'd0,
      COND_ZERO       = 3'd1,
      COND_XY_ODD     = 3'd2,
      COND_U_ODD      = 3'd3,
      COND_V_ODD      = 3'd4,
      COND_U_EQ_V     = 3'd5,
      COND_INV_NONNEG = 3'd6,
      COND_RSP_FULL   = 3'd7
   } cond_type;

   // one control word: when guard is set the operation is skipped if the condition holds
   typedef struct packed {
      op_type             op;
      logic               guard;
      cond_type           cond;
      logic [PC_BITS-1:0] tgt_true;
      logic [PC_BITS-1:0] tgt_false;
   } ucode_type;

   // status from datapath to sequencer
   typedef struct packed {
      logic zero;
      logic xy_odd;
      logic u_odd;
      logic v_odd;
      logic u_eq_v;
      logic inv_nonneg;
      logic rsp_full;
   } flags_type;

   // command from sequencer to datapath
   typedef struct packed {
      op_type op;
      logic   exec;
   } ctrl_type;

   // control program
   function automatic ucode_type ucode_rom(input logic [PC_BITS-1:0] pc);
      ucode_type w;
      unique case (pc)
         STEP_CHECK:   w = '{OP_NOP,     1'b0, COND_ZERO,       STEP_ERR,     STEP_STRIP};
         STEP_STRIP:   w = '{OP_STRIP,   1'b1, COND_XY_ODD,     STEP_INIT,    STEP_STRIP};
         STEP_INIT:    w = '{OP_INIT,    1'b0, COND_ALWAYS,     STEP_HALVE_U, STEP_HALVE_U};
         STEP_HALVE_U: w = '{OP_HALVE_U, 1'b1, COND_U_ODD,      STEP_HALVE_V, STEP_HALVE_U};
         STEP_HALVE_V: w = '{OP_HALVE_V, 1'b1, COND_V_ODD,      STEP_SUB,     STEP_HALVE_V};
         STEP_SUB:     w = '{OP_SUB,     1'b0, COND_U_EQ_V,     STEP_COPY,    STEP_HALVE_U};
         STEP_COPY:    w = '{OP_COPY,    1'b0, COND_ALWAYS,     STEP_FIX,     STEP_FIX};
         STEP_FIX:     w = '{OP_ADD_X,   1'b1, COND_INV_NONNEG, STEP_DONE,    STEP_FIX};
         STEP_DONE:    w = '{OP_FINISH,  1'b1, COND_RSP_FULL,   STEP_DONE,    STEP_DONE};
         STEP_ERR:     w = '{OP_ERR,     1'b0, COND_ALWAYS,     STEP_DONE,    STEP_DONE};
         default:      w = '{OP_NOP,     1'b0, COND_ALWAYS,     STEP_CHECK,   STEP_CHECK};
      endcase
      return w;
   endfunction

endpackage

// ----- design/bxg_if.sv -----
// bxg_if: request and response channel interfaces
`timescale 1ns / 1ps

interface bxg_req_if #(parameter int WIDTH = 32);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] modulus;
   logic [WIDTH-1:0] operand;

   modport source (output valid, output modulus, output operand, input ready);
   modport sink   (input valid, input modulus, input operand, output ready);
endinterface

interface bxg_rsp_if #(parameter int WIDTH = 32);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH+1:0] coef_modulus;
   logic signed [WIDTH+1:0] coef_operand;
   logic [WIDTH-1:0]        gcd_result;
   logic [WIDTH:0]          inverse;
   logic                    zero_error;

   modport source (output valid, output coef_modulus, output coef_operand,
                   output gcd_result, output inverse, output zero_error, input ready);
   modport sink   (input valid, input coef_modulus, input coef_operand,
                   input gcd_result, input inverse, input zero_error, output ready);
endinterface

// ----- design/bxg_sequencer.sv -----
// bxg_sequencer: step counter and control word lookup with conditional jumps
`timescale 1ns / 1ps

module bxg_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  bxg_pkg::flags_type flags,
   output bxg_pkg::ctrl_type  ctrl,
   output logic               busy
);

   logic [bxg_pkg::PC_BITS-1:0] pc_ff, pc_in;
   logic                        busy_ff, busy_in;
   bxg_pkg::ucode_type          word;
   logic                        cond_true;

   // fetch the current control word
   always_comb begin
      word = bxg_pkg::ucode_rom(pc_ff);
   end

   // evaluate the jump condition
   always_comb begin
      unique case (word.cond)
         bxg_pkg::COND_ALWAYS:     cond_true = 1'b1;
         bxg_pkg::COND_ZERO:       cond_true = flags.zero;
         bxg_pkg::COND_XY_ODD:     cond_true = flags.xy_odd;
         bxg_pkg::COND_U_ODD:      cond_true = flags.u_odd;
         bxg_pkg::COND_V_ODD:      cond_true = flags.v_odd;
         bxg_pkg::COND_U_EQ_V:     cond_true = flags.u_eq_v;
         bxg_pkg::COND_INV_NONNEG: cond_true = flags.inv_nonneg;
         bxg_pkg::COND_RSP_FULL:   cond_true = flags.rsp_full;
         default:                  cond_true = 1'b1;
      endcase
   end

   // issue the operation unless its guard condition holds
   always_comb begin
      ctrl.op   = word.op;
      ctrl.exec = busy_ff && !(word.guard && cond_true);
   end

   // next step and busy flag
   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      priority if (start) begin
         pc_in   = bxg_pkg::STEP_CHECK;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         pc_in = cond_true ? word.tgt_true : word.tgt_false;
         if (ctrl.exec && (word.op == bxg_pkg::OP_FINISH)) begin
            busy_in = 1'b0;
         end
      end else begin
         pc_in   = pc_ff;
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= bxg_pkg::STEP_CHECK;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ----- design/bxg_datapath.sv -----
// bxg_datapath: operand, coefficient and result registers with shared halving and subtract units
`timescale 1ns / 1ps

module bxg_datapath #(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic [WIDTH-1:0]        load_modulus,
   input  logic [WIDTH-1:0]        load_operand,
   input  bxg_pkg::ctrl_type       ctrl,
   output bxg_pkg::flags_type      flags,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic signed [WIDTH+1:0] rsp_coef_modulus,
   output logic signed [WIDTH+1:0] rsp_coef_operand,
   output logic [WIDTH-1:0]        rsp_gcd_result,
   output logic [WIDTH:0]          rsp_inverse,
   output logic                    rsp_zero_error
);

   // coefficients carry three guard bits above the operand width
   localparam int EXT = 3;
   localparam int CW  = WIDTH + EXT;
   localparam int SHW = $clog2(WIDTH);

   logic [WIDTH-1:0]     x_ff, x_in;
   logic [WIDTH-1:0]     xs_ff, xs_in, ys_ff, ys_in;
   logic [WIDTH-1:0]     u_ff, u_in, v_ff, v_in;
   logic signed [CW-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic signed [CW-1:0] inv_ff, inv_in;
   logic [SHW-1:0]       shift_ff, shift_in;
   logic                 err_ff, err_in;

   logic                    valid_ff, valid_in;
   logic signed [WIDTH+1:0] coef_m_ff, coef_m_in, coef_o_ff, coef_o_in;
   logic [WIDTH-1:0]        gcd_ff, gcd_in;
   logic [WIDTH:0]          inv_out_ff, inv_out_in;
   logic                    zerr_ff, zerr_in;

   logic signed [CW-1:0] xs_ext, ys_ext, x_ext;
   logic signed [CW-1:0] hp, hq, hp_sum, hq_sum, hp_half, hq_half;
   logic                 u_ge_v;
   logic [WIDTH-1:0]     s_big, s_small, s_diff;
   logic signed [CW-1:0] sp_big, sp_small, sq_big, sq_small, sp_diff, sq_diff;
   logic                 finish;

   assign xs_ext = {{EXT{1'b0}}, xs_ff};
   assign ys_ext = {{EXT{1'b0}}, ys_ff};
   assign x_ext  = {{EXT{1'b0}}, x_ff};

   // status for the sequencer
   always_comb begin
      flags.zero       = (xs_ff == '0) || (ys_ff == '0);
      flags.xy_odd     = xs_ff[0] | ys_ff[0];
      flags.u_odd      = u_ff[0];
      flags.v_odd      = v_ff[0];
      flags.u_eq_v     = (u_ff == v_ff);
      flags.inv_nonneg = !inv_ff[CW-1];
      flags.rsp_full   = valid_ff && !rsp_ready;
   end

   // shared halving unit for the (a, b) or (c, d) pair
   always_comb begin
      hp = (ctrl.op == bxg_pkg::OP_HALVE_U) ? a_ff : c_ff;
      hq = (ctrl.op == bxg_pkg::OP_HALVE_U) ? b_ff : d_ff;
      if ((hp[0] | hq[0]) == 1'b0) begin
         hp_sum = hp;
         hq_sum = hq;
      end else begin
         hp_sum = hp + ys_ext;
         hq_sum = hq - xs_ext;
      end
      hp_half = {hp_sum[CW-1], hp_sum[CW-1:1]};
      hq_half = {hq_sum[CW-1], hq_sum[CW-1:1]};
   end

   // shared subtract unit: larger working value loses the smaller
   always_comb begin
      u_ge_v   = (u_ff >= v_ff);
      s_big    = u_ge_v ? u_ff : v_ff;
      s_small  = u_ge_v ? v_ff : u_ff;
      sp_big   = u_ge_v ? a_ff : c_ff;
      sp_small = u_ge_v ? c_ff : a_ff;
      sq_big   = u_ge_v ? b_ff : d_ff;
      sq_small = u_ge_v ? d_ff : b_ff;
      s_diff   = s_big - s_small;
      sp_diff  = sp_big - sp_small;
      sq_diff  = sq_big - sq_small;
   end

   // working register updates
   always_comb begin
      x_in     = x_ff;
      xs_in    = xs_ff;
      ys_in    = ys_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      inv_in   = inv_ff;
      shift_in = shift_ff;
      err_in   = err_ff;
      finish   = 1'b0;
      if (load) begin
         x_in     = load_modulus;
         xs_in    = load_modulus;
         ys_in    = load_operand;
         shift_in = '0;
         err_in   = 1'b0;
      end else if (ctrl.exec) begin
         unique case (ctrl.op)
            bxg_pkg::OP_NOP: begin
            end
            bxg_pkg::OP_STRIP: begin
               xs_in    = xs_ff >> 1;
               ys_in    = ys_ff >> 1;
               shift_in = shift_ff + SHW'(1);
            end
            bxg_pkg::OP_INIT: begin
               u_in = xs_ff;
               v_in = ys_ff;
               a_in = CW'(1);
               b_in = '0;
               c_in = '0;
               d_in = CW'(1);
            end
            bxg_pkg::OP_HALVE_U: begin
               u_in = u_ff >> 1;
               a_in = hp_half;
               b_in = hq_half;
            end
            bxg_pkg::OP_HALVE_V: begin
               v_in = v_ff >> 1;
               c_in = hp_half;
               d_in = hq_half;
            end
            bxg_pkg::OP_SUB: begin
               if (u_ge_v) begin
                  u_in = s_diff;
                  a_in = sp_diff;
                  b_in = sq_diff;
               end else begin
                  v_in = s_diff;
                  c_in = sp_diff;
                  d_in = sq_diff;
               end
            end
            bxg_pkg::OP_COPY: begin
               inv_in = d_ff;
            end
            bxg_pkg::OP_ADD_X: begin
               inv_in = inv_ff + x_ext;
            end
            bxg_pkg::OP_FINISH: begin
               finish = 1'b1;
            end
            bxg_pkg::OP_ERR: begin
               c_in     = '0;
               d_in     = '0;
               v_in     = '0;
               inv_in   = '0;
               shift_in = '0;
               err_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // response register
   always_comb begin
      coef_m_in  = coef_m_ff;
      coef_o_in  = coef_o_ff;
      gcd_in     = gcd_ff;
      inv_out_in = inv_out_ff;
      zerr_in    = zerr_ff;
      valid_in   = valid_ff && !rsp_ready;
      if (finish) begin
         coef_m_in  = c_ff[WIDTH+1:0];
         coef_o_in  = d_ff[WIDTH+1:0];
         gcd_in     = v_ff << shift_ff;
         inv_out_in = inv_ff[WIDTH:0];
         zerr_in    = err_ff;
         valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      xs_ff      <= xs_in;
      ys_ff      <= ys_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      d_ff       <= d_in;
      inv_ff     <= inv_in;
      shift_ff   <= shift_in;
      err_ff     <= err_in;
      coef_m_ff  <= coef_m_in;
      coef_o_ff  <= coef_o_in;
      gcd_ff     <= gcd_in;
      inv_out_ff <= inv_out_in;
      zerr_ff    <= zerr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_coef_modulus = coef_m_ff;
   assign rsp_coef_operand = coef_o_ff;
   assign rsp_gcd_result   = gcd_ff;
   assign rsp_inverse      = inv_out_ff;
   assign rsp_zero_error   = zerr_ff;

endmodule

// ----- design/binary_extended_gcd_inverse.sv -----
// binary_extended_gcd_inverse: top level of the binary extended gcd and modular inverse block
//
//   channel  dir  handshake     payload
//   req_bus  in   valid/ready   modulus, operand
//   rsp_bus  out  valid/ready   coef_modulus, coef_operand, gcd_result, inverse, zero_error
//
// One control word runs per cycle on a single shared datapath: the zero check, the
// stripping of the common power of two s, the halving and subtraction passes, and the
// k modulus additions of the inverse fix-up run as steps before the registered result;
// every subtraction pass drops at least one bit of u or v.
// A zero operand goes through the check, error and done steps. One item is in flight at a time.
// Synchronous active-high reset clears the step counter, busy flag and response valid.
// A stalled response holds; the next request is taken once the result is registered.
`timescale 1ns / 1ps

module binary_extended_gcd_inverse #(
   parameter int WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   bxg_req_if.sink    req_bus,
   bxg_rsp_if.source  rsp_bus
);

   bxg_pkg::flags_type flags;
   bxg_pkg::ctrl_type  ctrl;
   logic               busy;
   logic               start;

   // a request is taken whenever the sequencer is free
   assign req_bus.ready = !busy;
   assign start         = req_bus.valid && !busy;

   bxg_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   bxg_datapath #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .load             (start),
      .load_modulus     (req_bus.modulus),
      .load_operand     (req_bus.operand),
      .ctrl             (ctrl),
      .flags            (flags),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_coef_modulus (rsp_bus.coef_modulus),
      .rsp_coef_operand (rsp_bus.coef_operand),
      .rsp_gcd_result   (rsp_bus.gcd_result),
      .rsp_inverse      (rsp_bus.inverse),
      .rsp_zero_error   (rsp_bus.zero_error)
   );

endmodule

// ----- design/bxg_checker.sv -----
// bxg_checker: port-level assertions for the gcd block and their binding
`timescale 1ns / 1ps

module bxg_checker #(
   parameter int WIDTH = 32
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [WIDTH+1:0] rsp_coef_modulus,
   input logic signed [WIDTH+1:0] rsp_coef_operand,
   input logic [WIDTH-1:0]        rsp_gcd_result,
   input logic [WIDTH:0]          rsp_inverse,
   input logic                    rsp_zero_error
);

   // the block works on one request at a time
   property busy_after_accept;
      @(posedge clock) disable iff (reset)
         (req_valid && req_ready) |=> !req_ready;
   endproperty
   assert property (busy_after_accept) else $error("request taken while busy");

   // no result can appear the cycle after a request is taken
   property no_instant_result;
      @(posedge clock) disable iff (reset)
         (req_valid && req_ready) |=> !$rose(rsp_valid);
   endproperty
   assert property (no_instant_result) else $error("result too early after request");

   // zero operand gives an all-zero result
   property zero_result_clear;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_zero_error) |->
            (rsp_coef_modulus == '0) && (rsp_coef_operand == '0) &&
            (rsp_gcd_result == '0) && (rsp_inverse == '0);
   endproperty
   assert property (zero_result_clear) else $error("error result not cleared");

   // a stalled result holds
   property rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=>
            rsp_valid && $stable(rsp_coef_modulus) && $stable(rsp_coef_operand) &&
            $stable(rsp_gcd_result) && $stable(rsp_inverse) && $stable(rsp_zero_error);
   endproperty
   assert property (rsp_hold) else $error("stalled result changed");

endmodule

bind binary_extended_gcd_inverse bxg_checker #(
   .WIDTH (WIDTH)
) u_bxg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_coef_modulus (rsp_bus.coef_modulus),
   .rsp_coef_operand (rsp_bus.coef_operand),
   .rsp_gcd_result   (rsp_bus.gcd_result),
   .rsp_inverse      (rsp_bus.inverse),
   .rsp_zero_error   (rsp_bus.zero_error)
);

// ----- sim/tb_binary_extended_gcd_inverse.sv -----
// tb_binary_extended_gcd_inverse: self-checking testbench for the binary extended gcd and inverse block
`timescale 1ns / 1ps

module tb_binary_extended_gcd_inverse;

   localparam int WIDTH          = 32;
   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 1830;
   localparam int QUIET_ITEMS    = 200;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int TAIL_CYCLES    = 400;
   localparam int CYCLE_LIMIT    = 2000000;

   // one result as the block presents it
   typedef struct packed {
      logic signed [WIDTH+1:0] coef_modulus;
      logic signed [WIDTH+1:0] coef_operand;
      logic [WIDTH-1:0]        gcd_result;
      logic [WIDTH:0]          inverse;
      logic                    zero_error;
   } gcd_rsp_type;

   // one row of the directed table, with a typed-in result where known
   typedef struct packed {
      logic [WIDTH-1:0] modulus;
      logic [WIDTH-1:0] operand;
      logic             typed;
      gcd_rsp_type      want;
   } stim_row_type;

   localparam gcd_rsp_type ZERO_ERROR_RSP = {34'd0, 34'd0, 32'd0, 33'd0, 1'b1};

   logic clock = 1'b0;
   logic reset = 1'b1;

   bxg_req_if #(.WIDTH(WIDTH)) req_bus ();
   bxg_rsp_if #(.WIDTH(WIDTH)) rsp_bus ();

   binary_extended_gcd_inverse #(.WIDTH(WIDTH)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   gcd_rsp_type  pending_results [$];
   stim_row_type directed_table [$];
   int           error_count      = 0;
   int           cycle_count      = 0;
   bit           hold_off_request = 1'b0;
   bit           quiet_tail       = 1'b0;

   // clock
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_binary_extended_gcd_inverse: done, errors");
         $finish;
      end
   end

   // exact halving of an even two's complement value
   function automatic logic [63:0] halve_exact(input logic [63:0] val);
      return {val[63], val[63:1]};
   endfunction

   // expected coefficients, gcd and inverse of one request
   function automatic gcd_rsp_type gcd_inverse_of(input logic [WIDTH-1:0] m,
                                                  input logic [WIDTH-1:0] o);
      gcd_rsp_type r;
      logic [63:0] x, y, xs, ys, u, v, a, b, c, d, inv, neg, k, g;
      int          shift;
      r     = '0;
      x     = 64'(m);
      y     = 64'(o);
      shift = 0;
      if (x == 64'd0 || y == 64'd0) begin
         r.zero_error = 1'b1;
         return r;
      end
      // strip the common power of two
      xs = x;
      ys = y;
      while (!xs[0] && !ys[0]) begin
         xs = xs >> 1;
         ys = ys >> 1;
         shift++;
      end
      u = xs;
      v = ys;
      a = 64'd1;
      b = 64'd0;
      c = 64'd0;
      d = 64'd1;
      // halve and subtract until u runs out
      while (u != 64'd0) begin
         while (!u[0]) begin
            u = u >> 1;
            if (!a[0] && !b[0]) begin
               a = halve_exact(a);
               b = halve_exact(b);
            end else begin
               a = halve_exact(a + ys);
               b = halve_exact(b - xs);
            end
         end
         while (!v[0]) begin
            v = v >> 1;
            if (!c[0] && !d[0]) begin
               c = halve_exact(c);
               d = halve_exact(d);
            end else begin
               c = halve_exact(c + ys);
               d = halve_exact(d - xs);
            end
         end
         if (u >= v) begin
            u = u - v;
            a = a - c;
            b = b - d;
         end else begin
            v = v - u;
            c = c - a;
            d = d - b;
         end
      end
      // raise the operand coefficient by the modulus until nonnegative
      inv = d;
      if (d[63]) begin
         neg = -d;
         k   = (neg + x - 64'd1) / x;
         inv = d + k * x;
      end
      g              = v << shift;
      r.coef_modulus = c[WIDTH+1:0];
      r.coef_operand = d[WIDTH+1:0];
      r.gcd_result   = g[WIDTH-1:0];
      r.inverse      = inv[WIDTH:0];
      return r;
   endfunction

   // random operand pair, modulus in the upper half
   function automatic logic [2*WIDTH-1:0] random_pair();
      logic [WIDTH-1:0] m, o;
      int               k;
      case ($urandom_range(0, 19))
         6, 7, 8: begin
            m = $urandom | 32'd1;
            o = $urandom;
         end
         9, 10: begin
            m = $urandom_range(1, 255);
            o = $urandom_range(1, 255);
         end
         11, 12: begin
            k = $urandom_range(1, 31);
            m = ($urandom | 32'd1) << k;
            o = ($urandom | 32'd1) << $urandom_range(1, 31);
         end
         13: begin
            m = $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
            o = $urandom;
            if ($urandom_range(0, 1)) {m, o} = {o, m};
         end
         14: begin
            m = $urandom;
            o = m;
         end
         15: begin
            m = $urandom;
            o = $urandom;
            case ($urandom_range(0, 2))
               0: m = '0;
               1: o = '0;
               default: begin
                  m = '0;
                  o = '0;
               end
            endcase
         end
         16: begin
            m = 32'd1 << $urandom_range(0, 31);
            o = 32'd1 << $urandom_range(0, 31);
         end
         17: begin
            m = $urandom;
            o = m - $urandom_range(0, 3);
         end
         18, 19: begin
            m = $urandom_range(1, 65535);
            o = $urandom;
         end
         default: begin
            m = $urandom;
            o = $urandom;
         end
      endcase
      return {m, o};
   endfunction

   task automatic table_row(input logic [WIDTH-1:0] m, input logic [WIDTH-1:0] o,
                            input logic typed, input gcd_rsp_type want);
      stim_row_type row;
      row.modulus = m;
      row.operand = o;
      row.typed   = typed;
      row.want    = want;
      directed_table.push_back(row);
   endtask

   // offer one request, with an occasional idle burst first; called at a falling edge
   task automatic offer_request(input logic [WIDTH-1:0] m, input logic [WIDTH-1:0] o,
                                input gcd_rsp_type want);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.modulus = m;
      req_bus.operand = o;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(want);
      @(negedge clock);
   endtask

   // stop offering until every outstanding result is back
   task automatic wait_for_results();
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic flag_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
         error_count++;
      end
   endtask

   // result sink: random stall bursts, one long hold-off on request
   initial begin : result_sink
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_request = 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready = 1'b0;
            stall_left    = $urandom_range(1, 15) - 1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // compare every accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      gcd_rsp_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.coef_modulus, rsp_bus.coef_operand, rsp_bus.gcd_result,
                rsp_bus.inverse, rsp_bus.zero_error};
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected, got %h", $time, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            flag_field("coef_modulus", 64'(want.coef_modulus), 64'(got.coef_modulus));
            flag_field("coef_operand", 64'(want.coef_operand), 64'(got.coef_operand));
            flag_field("gcd_result", 64'(want.gcd_result), 64'(got.gcd_result));
            flag_field("inverse", 64'(want.inverse), 64'(got.inverse));
            flag_field("zero_error", 64'(want.zero_error), 64'(got.zero_error));
         end
      end
   end

   // stimulus
   initial begin : stimulus
      stim_row_type       row;
      logic [2*WIDTH-1:0] pair;
      int                 n;
      req_bus.valid   = 1'b0;
      req_bus.modulus = '0;
      req_bus.operand = '0;

      // zero operands, equal values, extremes and small hand cases
      table_row(32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_ERROR_RSP);
      table_row(32'h0000_0000, 32'hffff_ffff, 1'b1, ZERO_ERROR_RSP);
      table_row(32'hffff_ffff, 32'h0000_0000, 1'b1, ZERO_ERROR_RSP);
      table_row(32'h0000_0000, 32'h0000_0001, 1'b1, ZERO_ERROR_RSP);
      table_row(32'h0000_0001, 32'h0000_0001, 1'b1, {34'd0, 34'd1, 32'd1, 33'd1, 1'b0});
      table_row(32'hffff_ffff, 32'hffff_ffff, 1'b1,
                {34'd0, 34'd1, 32'hffff_ffff, 33'd1, 1'b0});
      table_row(32'h8000_0000, 32'h8000_0000, 1'b1,
                {34'd0, 34'd1, 32'h8000_0000, 33'd1, 1'b0});
      table_row(32'hffff_ffff, 32'h0000_0001, 1'b0, '0);
      table_row(32'h0000_0001, 32'hffff_ffff, 1'b0, '0);
      table_row(32'hffff_fffe, 32'hffff_ffff, 1'b0, '0);
      table_row(32'hffff_ffff, 32'hffff_fffe, 1'b0, '0);
      table_row(32'h8000_0000, 32'h4000_0000, 1'b0, '0);
      table_row(32'h4000_0000, 32'h8000_0000, 1'b0, '0);
      table_row(32'h0000_000d, 32'h0000_0007, 1'b0, '0);
      table_row(32'h0000_0007, 32'h0000_000d, 1'b0, '0);
      table_row(32'h0000_000c, 32'h0000_0012, 1'b0, '0);
      table_row(32'h0000_0003, 32'h0000_0006, 1'b0, '0);
      table_row(32'h0000_0006, 32'h0000_0003, 1'b0, '0);
      table_row(32'h0000_0002, 32'h0000_0003, 1'b0, '0);
      table_row(32'h0000_0003, 32'h0000_0002, 1'b0, '0);
      table_row(32'hffff_fffb, 32'h0000_0002, 1'b0, '0);
      table_row(32'haaaa_aaaa, 32'h5555_5555, 1'b0, '0);
      table_row(32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (n = 0; n < directed_table.size(); n++) begin
         row = directed_table[n];
         offer_request(row.modulus, row.operand,
                       row.typed ? row.want : gcd_inverse_of(row.modulus, row.operand));
      end
      wait_for_results();

      // random part, opening with a long hold-off at the result side
      hold_off_request = 1'b1;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) wait_for_results();
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
         pair = random_pair();
         offer_request(pair[2*WIDTH-1:WIDTH], pair[WIDTH-1:0],
                       gcd_inverse_of(pair[2*WIDTH-1:WIDTH], pair[WIDTH-1:0]));
      end

      // drain, then watch for stray results
      wait_for_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("tb_binary_extended_gcd_inverse: done, clean");
      end else begin
         $display("tb_binary_extended_gcd_inverse: done, errors");
      end
      $finish;
   end

endmodule
